// File: rtl/fwpi_pkg.sv
// ----------------------------------------------------------------------------
// fwpi_pkg
// Shared sizes, operation and status codes, and cell control codes for the
// queue with positional insert.
// ----------------------------------------------------------------------------
package fwpi_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the ports
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int POS_W  = 5;
  localparam int CAP_W  = 5;
  localparam int OCNT_W = 5;
  localparam int STAT_W = 2;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  // common width for count, limit and position compares
  localparam int WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_POP    = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_op_e;

endpackage

// File: rtl/fwpi_cell.sv
// ----------------------------------------------------------------------------
// fwpi_cell
// One slot of the queue: holds, loads a new word, or takes the word of the
// slot toward the head or toward the tail.
// ----------------------------------------------------------------------------
module fwpi_cell (
  input  logic                              clk_i,
  input  fwpi_pkg::cell_op_e                op_i,
  input  logic [fwpi_pkg::DATA_WIDTH-1:0]   load_i,
  input  logic [fwpi_pkg::DATA_WIDTH-1:0]   prev_i,
  input  logic [fwpi_pkg::DATA_WIDTH-1:0]   next_i,
  output logic [fwpi_pkg::DATA_WIDTH-1:0]   data_o
);

  logic [fwpi_pkg::DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      fwpi_pkg::CELL_LOAD: data_d = load_i;
      fwpi_pkg::CELL_PREV: data_d = prev_i;
      fwpi_pkg::CELL_NEXT: data_d = next_i;
      default:             data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/fifo_with_positional_insert.sv
// ----------------------------------------------------------------------------
// fifo_with_positional_insert
// Bounded queue of data words with append, insert at position and pop head.
// ----------------------------------------------------------------------------
// One beat is taken per clock cycle unless stalled; its result appears in the
// cycle after acceptance. Entries live in a row of slot cells, head in slot
// 0, and every cell picks hold, load, take-from-head-side or
// take-from-tail-side in the same cycle, so an insert or a pop updates the
// whole row at once. The result sits in an output register; while it is
// stalled the input is stalled too, otherwise a new beat enters each cycle.
// Capacity is written through cfg_we_i/cfg_wdata_i by the user only while idle
// (the block does not enforce this); its limit is clamped to the slot count.
// ----------------------------------------------------------------------------
module fifo_with_positional_insert (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fwpi_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fwpi_pkg::KIND_W-1:0]       kind_i,
  input  logic [fwpi_pkg::WORD_W-1:0]       value_i,
  input  logic [fwpi_pkg::POS_W-1:0]        position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fwpi_pkg::WORD_W-1:0]       popped_value_o,
  output logic                              popped_valid_o,
  output logic [fwpi_pkg::STAT_W-1:0]       status_o,
  output logic [fwpi_pkg::OCNT_W-1:0]       item_count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int WW = fwpi_pkg::WIDE_W;

  logic [fwpi_pkg::CAP_W-1:0]      cap_q;
  logic [fwpi_pkg::CNT_W-1:0]      count_q, count_d;
  logic                            out_valid_q;
  logic [fwpi_pkg::WORD_W-1:0]     pop_val_q;
  logic                            pop_vld_q;
  fwpi_pkg::status_e               status_q, status_d;
  logic [fwpi_pkg::OCNT_W-1:0]     ocnt_q;
  logic                            empty_q, full_q;

  logic                            in_acc;
  logic [WW-1:0]                   lim_w, cnt_w, pos_w, cnt_d_w;
  logic                            full_now, do_ins, do_pop;
  logic [fwpi_pkg::DATA_WIDTH-1:0] data   [fwpi_pkg::DEPTH];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    lim_w = (WW'(cap_q) > WW'(fwpi_pkg::DEPTH)) ? WW'(fwpi_pkg::DEPTH) : WW'(cap_q);
    cnt_w = WW'(count_q);
    full_now = cnt_w >= lim_w;
    if (kind_i == fwpi_pkg::KIND_APPEND || WW'(position_i) > cnt_w) begin
      pos_w = cnt_w;
    end else begin
      pos_w = WW'(position_i);
    end
    do_ins   = 1'b0;
    do_pop   = 1'b0;
    status_d = fwpi_pkg::ST_OK;
    count_d  = count_q;
    case (kind_i)
      fwpi_pkg::KIND_APPEND, fwpi_pkg::KIND_INSERT: begin
        if (full_now) begin
          status_d = fwpi_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      fwpi_pkg::KIND_POP: begin
        if (count_q == '0) begin
          status_d = fwpi_pkg::ST_EMPTY;
        end else begin
          do_pop  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    cnt_d_w = WW'(count_d);
  end

  for (genvar gi = 0; gi < fwpi_pkg::DEPTH; gi++) begin : g_cell
    logic [fwpi_pkg::DATA_WIDTH-1:0] prev_w, next_w;
    fwpi_pkg::cell_op_e              op_w;

    if (gi == 0) begin : g_head
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = data[gi-1];
    end
    if (gi == fwpi_pkg::DEPTH - 1) begin : g_tail
      assign next_w = data[gi];
    end else begin : g_body
      assign next_w = data[gi+1];
    end

    always_comb begin
      op_w = fwpi_pkg::CELL_HOLD;
      if (in_acc && do_ins) begin
        if (WW'(gi) == pos_w) begin
          op_w = fwpi_pkg::CELL_LOAD;
        end else if (WW'(gi) > pos_w) begin
          op_w = fwpi_pkg::CELL_PREV;
        end
      end else if (in_acc && do_pop) begin
        op_w = fwpi_pkg::CELL_NEXT;
      end
    end

    fwpi_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op_w),
      .load_i (value_i[fwpi_pkg::DATA_WIDTH-1:0]),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (data[gi])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= fwpi_pkg::CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pop_val_q <= do_pop ? fwpi_pkg::WORD_W'(data[0]) : '0;
      pop_vld_q <= do_pop;
      status_q  <= status_d;
      ocnt_q    <= cnt_d_w[fwpi_pkg::OCNT_W-1:0];
      empty_q   <= (count_d == '0);
      full_q    <= (cnt_d_w >= lim_w);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = pop_val_q;
  assign popped_valid_o = pop_vld_q;
  assign status_o       = status_q;
  assign item_count_o   = ocnt_q;
  assign is_empty_o     = empty_q;
  assign is_full_o      = full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fwpi_pkg::CNT_W'(fwpi_pkg::DEPTH))
    else $error("entry count beyond slot count");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && popped_valid_o) |-> (status_o == fwpi_pkg::ST_OK))
    else $error("popped word with non-ok status");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == fwpi_pkg::KIND_POP && count_q != '0)
    |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not decrement count");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == fwpi_pkg::KIND_APPEND || kind_i == fwpi_pkg::KIND_INSERT)
     && full_now) |=> $stable(count_q))
    else $error("rejected add changed count");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the queue with positional insert. A short directed
// table covers an empty pop, an unused kind, the word extremes, positions at
// and past the count and a full queue. Random phases under several capacity
// settings follow. Each beat is predicted by a queue model held in the bench,
// or by the table for typed steps, and compared field by field with the result
// beat, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [fwpi_pkg::KIND_W-1:0] KIND_NONE = 2'd3;  // unused kind, reports ok
  localparam int N_PLAN     = 24;
  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 153;
  localparam int HOLD_LEN   = 150;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [fwpi_pkg::WORD_W-1:0] popped;
    logic                        popped_ok;
    fwpi_pkg::status_e           code;
    logic [fwpi_pkg::OCNT_W-1:0] count;
    logic                        empty;
    logic                        full;
  } outcome_t;

  typedef struct packed {
    logic [fwpi_pkg::KIND_W-1:0] kind;
    logic [fwpi_pkg::WORD_W-1:0] value;
    logic [fwpi_pkg::POS_W-1:0]  pos;
    logic                        typed;
    outcome_t                    want;
  } step_t;

  localparam outcome_t NO_RES = '{32'h0, 1'b0, fwpi_pkg::ST_OK, 5'd0, 1'b0, 1'b0};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [fwpi_pkg::CAP_W-1:0]  cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [fwpi_pkg::KIND_W-1:0] kind_i = '0;
  logic [fwpi_pkg::WORD_W-1:0] value_i = '0;
  logic [fwpi_pkg::POS_W-1:0]  position_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [fwpi_pkg::WORD_W-1:0] popped_value_o;
  logic                        popped_valid_o;
  logic [fwpi_pkg::STAT_W-1:0] status_o;
  logic [fwpi_pkg::OCNT_W-1:0] item_count_o;
  logic                        is_empty_o;
  logic                        is_full_o;

  fifo_with_positional_insert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .popped_valid_o (popped_valid_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bench copy of the queue: head at index 0
  logic [fwpi_pkg::WORD_W-1:0] held_words[$];
  logic [fwpi_pkg::CAP_W-1:0]  cap_reg = fwpi_pkg::CAP_RESET;
  outcome_t                    results_due[$];
  int                          errors = 0;
  bit                          calm_in = 1'b0;
  bit                          calm_out = 1'b0;
  bit                          hold_req = 1'b0;
  step_t                       plan[N_PLAN];

  function automatic outcome_t apply_op(logic [fwpi_pkg::KIND_W-1:0] kind,
                                        logic [fwpi_pkg::WORD_W-1:0] value,
                                        logic [fwpi_pkg::POS_W-1:0] pos);
    outcome_t r;
    int       lim;
    int       at;
    lim = (cap_reg > fwpi_pkg::DEPTH) ? fwpi_pkg::DEPTH : int'(cap_reg);
    r = NO_RES;
    case (kind)
      fwpi_pkg::KIND_APPEND, fwpi_pkg::KIND_INSERT: begin
        if (held_words.size() >= lim) begin
          r.code = fwpi_pkg::ST_FULL;
        end else begin
          at = (kind == fwpi_pkg::KIND_APPEND || pos > held_words.size()) ?
               held_words.size() : int'(pos);
          held_words.insert(at, value);
        end
      end
      fwpi_pkg::KIND_POP: begin
        if (held_words.size() == 0) begin
          r.code = fwpi_pkg::ST_EMPTY;
        end else begin
          r.popped    = held_words.pop_front();
          r.popped_ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = fwpi_pkg::OCNT_W'(held_words.size());
    r.empty = held_words.size() == 0;
    r.full  = held_words.size() >= lim;
    return r;
  endfunction

  function automatic int draw_wait();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
  endfunction

  task automatic offer(logic [fwpi_pkg::KIND_W-1:0] k, logic [fwpi_pkg::WORD_W-1:0] v,
                       logic [fwpi_pkg::POS_W-1:0] p, logic typed, outcome_t want);
    int       gap;
    outcome_t pred;
    gap = calm_in ? 0 : draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    value_i    <= v;
    position_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_op(k, v, p);
    results_due.push_back(typed ? want : pred);
  endtask

  // drop valid, wait for every pending result, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [fwpi_pkg::CAP_W-1:0] cap);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = cap;
  endtask

  task automatic random_beat(bit fill);
    int                          r;
    logic [fwpi_pkg::KIND_W-1:0] k;
    logic [fwpi_pkg::WORD_W-1:0] v;
    logic [fwpi_pkg::POS_W-1:0]  p;
    r = $urandom_range(0, 99);
    if (r < 4) k = KIND_NONE;
    else if (r < (fill ? 70 : 45))
      k = $urandom_range(0, 1) ? fwpi_pkg::KIND_INSERT : fwpi_pkg::KIND_APPEND;
    else k = fwpi_pkg::KIND_POP;
    if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    else v = $urandom();
    if ($urandom_range(0, 3) == 0) p = fwpi_pkg::POS_W'($urandom_range(0, 31));
    else p = fwpi_pkg::POS_W'($urandom_range(0, held_words.size() + 1));
    offer(k, v, p, 1'b0, NO_RES);
  endtask

  // result side: check each beat, then draw a stall for the next one
  initial begin : result_side
    int       wait_left;
    int       hold_left;
    outcome_t got;
    outcome_t want;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{popped_value_o, popped_valid_o, fwpi_pkg::status_e'(status_o), item_count_o,
                is_empty_o, is_full_o};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = results_due.pop_front();
          if (got.popped !== want.popped || got.popped_ok !== want.popped_ok ||
              got.code !== want.code || got.count !== want.count ||
              got.empty !== want.empty || got.full !== want.full) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp val=%h vld=%0d st=%0d cnt=%0d e=%0d f=%0d,",
                       want.popped, want.popped_ok, want.code, want.count, want.empty,
                       want.full,
                       " got val=%h vld=%0d st=%0d cnt=%0d e=%0d f=%0d",
                       got.popped, got.popped_ok, got.code, got.count,
                       got.empty, got.full);
          end
        end
        wait_left = calm_out ? 0 : draw_wait();
      end else if (wait_left > 0) begin
        wait_left--;
      end
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (wait_left > 0) || (hold_left > 0);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("fifo_with_positional_insert test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [fwpi_pkg::CAP_W-1:0] caps[N_PHASES];
    caps = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd2, 5'd7, 5'd16, 5'd15, 5'd3, 5'd12};
    plan = '{
      '{fwpi_pkg::KIND_POP,    32'h0,         5'd0,  1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0}},
      '{KIND_NONE,             32'h0,         5'd0,  1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_OK,    5'd0, 1'b1, 1'b0}},
      '{fwpi_pkg::KIND_APPEND, 32'hFFFF_FFFF, 5'd0,  1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_OK,    5'd1, 1'b0, 1'b0}},
      '{fwpi_pkg::KIND_APPEND, 32'h0,         5'd31, 1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_OK,    5'd2, 1'b0, 1'b0}},
      '{fwpi_pkg::KIND_INSERT, 32'hA5A5_A5A5, 5'd0,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'h5A5A_5A5A, 5'd31, 1'b0, NO_RES},  // past count: lands at tail
      '{fwpi_pkg::KIND_INSERT, 32'h1234_5678, 5'd2,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_POP,    32'hFFFF_FFFF, 5'd31, 1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'h0000_0001, 5'd16, 1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'h8000_0000, 5'd5,  1'b0, NO_RES},  // position equal to count
      '{fwpi_pkg::KIND_INSERT, 32'hDEAD_BEEF, 5'd1,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_APPEND, 32'h0F0F_0F0F, 5'd0,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'hF0F0_F0F0, 5'd15, 1'b0, NO_RES},
      '{fwpi_pkg::KIND_APPEND, 32'h3333_3333, 5'd0,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'hCCCC_CCCC, 5'd8,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_APPEND, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'h5555_5555, 5'd0,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_APPEND, 32'hAAAA_AAAA, 5'd0,  1'b0, NO_RES},
      '{fwpi_pkg::KIND_INSERT, 32'h0BAD_F00D, 5'd30, 1'b0, NO_RES},
      '{fwpi_pkg::KIND_APPEND, 32'hFEED_0001, 5'd0,  1'b0, NO_RES},  // reaches sixteen: full
      '{fwpi_pkg::KIND_APPEND, 32'h1111_1111, 5'd0,  1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_FULL, 5'd16, 1'b0, 1'b1}},
      '{fwpi_pkg::KIND_INSERT, 32'h2222_2222, 5'd0,  1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_FULL, 5'd16, 1'b0, 1'b1}},
      '{KIND_NONE,             32'hFFFF_FFFF, 5'd31, 1'b1,
        '{32'h0, 1'b0, fwpi_pkg::ST_OK,   5'd16, 1'b0, 1'b1}},
      '{fwpi_pkg::KIND_POP,    32'h0,         5'd0,  1'b0, NO_RES}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_PLAN; i++)
      offer(plan[i].kind, plan[i].value, plan[i].pos, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_capacity(caps[ph]);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        // receiver holds off while the sender keeps pushing beats
        calm_in  = 1'b1;
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_LEN; n++) random_beat(ph[0] == 1'b0);
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (results_due.size() != 0) errors++;
    if (errors == 0) $display("fifo_with_positional_insert test passed");
    else $display("fifo_with_positional_insert test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/fwpi_pkg.sv
rtl/fwpi_cell.sv
rtl/fifo_with_positional_insert.sv
test/tb_top.sv
